/* hdl/tws_pkg.sv */
// Shared constants and control/status types of the trie word store.
`default_nettype none
package tws_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int ALPHABET_DEF   = 26;

	// operation codes of an item
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND    = 2'd1;
	localparam logic [1:0] ST_POOL_FULL    = 2'd2;
	localparam logic [1:0] ST_EMPTY_DELETE = 2'd3;

	typedef struct packed {
		logic clr_step;  // clear one child entry
		logic accept;    // item transfer, child read issued
		logic link;      // follow or allocate the child
		logic mark_rd;   // read word mark of the end node
		logic finish;    // produce result, reset walk
	} tws_cmd_t;

	typedef struct packed {
		logic clr_last;   // clearing pass on its final entry
		logic letter_ok;  // incoming letter inside the alphabet
		logic walk_stop;  // walk failed or pool ran out
		logic item_last;  // held item ends the word
		logic out_busy;   // result register full and stalled
	} tws_stat_t;

endpackage
`default_nettype wire

/* hdl/tws_ctrl.sv */
// Sequencer of the trie word store: clearing pass and per-item steps.
`default_nettype none
module tws_ctrl
	import tws_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire logic      has_letter,
	input  wire logic      last,
	input  wire tws_stat_t stat,
	output tws_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LINK,
		S_MARK,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;
	logic   accept;

	assign accept     = (state_q == S_IDLE) && item_valid;
	assign item_stall = stall_q;

	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == S_CLEAR);
		cmd.accept   = accept;
		cmd.link     = (state_q == S_LINK);
		cmd.mark_rd  = (state_q == S_MARK);
		cmd.finish   = (state_q == S_FINISH) && !stat.out_busy;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (has_letter && stat.letter_ok && !stat.walk_stop) state_d = S_LINK;
					else if (last) state_d = S_MARK;
				end
			end
			S_LINK: begin
				state_d = stat.item_last ? S_MARK : S_IDLE;
			end
			S_MARK: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			stall_q <= 1'b1;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

endmodule
`default_nettype wire

/* hdl/tws_datapath.sv */
// Child-link and word-mark memories, walk registers, allocator and result register.
`default_nettype none
module tws_datapath
	import tws_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ALPHABET   = ALPHABET_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tws_cmd_t   cmd,
	output tws_stat_t       stat,
	input  wire logic [1:0] kind,
	input  wire logic [4:0] letter,
	input  wire logic       has_letter,
	input  wire logic       last,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      status,
	output logic [9:0]      end_node
);

	localparam int DEPTH = NODE_COUNT * ALPHABET;
	localparam int NW    = $clog2(NODE_COUNT);
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] ALPHA_A    = AW'(ALPHABET);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
	localparam logic [8:0]    ALPHA_L    = 9'(ALPHABET);
	localparam logic [NW:0]   NODES_N    = (NW + 1)'(NODE_COUNT);

	logic [NW-1:0] child_mem [DEPTH];
	logic          mark_mem  [NODE_COUNT];

	logic [AW-1:0] clr_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] slot_d;
	logic [NW-1:0] rd_child_q;
	logic          mark_rd_q;
	logic          root_mark_q;
	logic [1:0]    kind_q;
	logic          last_q;
	logic [NW-1:0] walk_q;
	logic          failed_q;
	logic          exhausted_q;
	logic [NW:0]   next_free_q;
	logic          result_valid_q;
	logic [1:0]    status_q;
	logic [NW-1:0] node_q;
	logic [NW+9:0] node_ext;

	logic          pool_full;
	logic          do_alloc;
	logic          walk_root;
	logic          empty_word;
	logic          cur_mark;
	logic          mark_wr;
	logic          mark_val;
	logic [1:0]    fin_status;
	logic          fin_hit;

	assign slot_d    = AW'(AW'(walk_q) * ALPHA_A + AW'(letter));
	assign pool_full = (next_free_q >= NODES_N);
	assign do_alloc  = cmd.link && (rd_child_q == '0) && (kind_q == KIND_INSERT) && !pool_full;

	assign stat.clr_last  = (clr_q == LAST_SLOT);
	assign stat.letter_ok = ({4'b0, letter} < ALPHA_L);
	assign stat.walk_stop = failed_q || exhausted_q;
	assign stat.item_last = last_q;
	assign stat.out_busy  = result_valid_q && result_stall;

	// result of the word at its final item
	assign walk_root  = (walk_q == '0);
	assign empty_word = walk_root && !failed_q && !exhausted_q;
	assign cur_mark   = walk_root ? root_mark_q : mark_rd_q;

	always_comb begin
		fin_status = ST_OK;
		fin_hit    = 1'b0;
		mark_wr    = 1'b0;
		mark_val   = 1'b0;
		if (kind_q == KIND_INSERT) begin
			if (exhausted_q) begin
				fin_status = ST_POOL_FULL;
			end else if (failed_q) begin
				fin_status = ST_NOT_FOUND;
			end else begin
				fin_hit  = 1'b1;
				mark_wr  = 1'b1;
				mark_val = 1'b1;
			end
		end else if ((kind_q == KIND_DELETE) && empty_word) begin
			fin_status = ST_EMPTY_DELETE;
		end else if (failed_q || exhausted_q || !cur_mark) begin
			fin_status = ST_NOT_FOUND;
		end else begin
			fin_hit = 1'b1;
			if (kind_q == KIND_DELETE) begin
				mark_wr = 1'b1;
			end
		end
	end

	// child-link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			child_mem[clr_q] <= '0;
		end else if (do_alloc) begin
			child_mem[slot_q] <= next_free_q[NW-1:0];
		end
		rd_child_q <= child_mem[slot_d];
	end

	// word-mark memory; the root mark lives in a register
	always_ff @(posedge clk) begin
		if (do_alloc) begin
			mark_mem[next_free_q[NW-1:0]] <= 1'b0;
		end else if (cmd.finish && mark_wr && !walk_root) begin
			mark_mem[walk_q] <= mark_val;
		end
		if (cmd.mark_rd) begin
			mark_rd_q <= mark_mem[walk_q];
		end
	end

	// item payload and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			last_q <= last;
			slot_q <= slot_d;
		end
		if (cmd.finish) begin
			status_q <= fin_status;
			node_q   <= fin_hit ? walk_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			walk_q         <= '0;
			failed_q       <= 1'b0;
			exhausted_q    <= 1'b0;
			next_free_q    <= (NW + 1)'(1);
			root_mark_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept && has_letter && !stat.walk_stop && !stat.letter_ok) begin
				failed_q <= 1'b1;
			end
			if (cmd.link) begin
				if (rd_child_q != '0) begin
					walk_q <= rd_child_q;
				end else if (kind_q != KIND_INSERT) begin
					failed_q <= 1'b1;
				end else if (pool_full) begin
					exhausted_q <= 1'b1;
				end else begin
					walk_q      <= next_free_q[NW-1:0];
					next_free_q <= next_free_q + (NW + 1)'(1);
				end
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (mark_wr && walk_root) begin
					root_mark_q <= mark_val;
				end
				result_valid_q <= 1'b1;
				walk_q         <= '0;
				failed_q       <= 1'b0;
				exhausted_q    <= 1'b0;
			end
		end
	end

	assign node_ext     = {10'b0, node_q};
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign end_node     = node_ext[9:0];

endmodule
`default_nettype wire

/* hdl/trie_word_store.sv */
// Top level of the trie word store: sequencer plus memory datapath.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    kind, letter, has_letter, last
//  result    out        result_valid / result_stall status, end_node
//
// In a letter item, the transfer cycle reads the child link of the
// current node, and the next cycle follows it or writes a newly allocated link.
// A letter past the alphabet, or one that arrives after the walk has stopped,
// needs only its transfer; so does a letterless item that does not end a word.
// The item that ends a word adds a step that reads the word mark of the end
// node, then a finish step that writes the mark and loads the result register.
// After reset the child-link memory is cleared one entry a cycle, through all
// NODE_COUNT * ALPHABET entries (26624 with the defaults); item_stall holds high.
// The result register frees the input side: a new item is taken while a result
// waits; only the end of a further word waits while result_stall is high.
`default_nettype none
module trie_word_store
	import tws_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ALPHABET   = ALPHABET_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// item channel
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [1:0] kind,
	input  wire logic [4:0] letter,
	input  wire logic       has_letter,
	input  wire logic       last,
	// result channel
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      status,
	output logic [9:0]      end_node
);

	tws_cmd_t  cmd;   // step requests from the sequencer
	tws_stat_t stat;  // walk and clearing status back to it

	// Sequencer: clearing pass, then transfer, link, mark read, finish.
	tws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.has_letter (has_letter),
		.last       (last),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Datapath: both memories, walk state, bump allocator, result register.
	tws_datapath #(
		.NODE_COUNT (NODE_COUNT),
		.ALPHABET   (ALPHABET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.letter       (letter),
		.has_letter   (has_letter),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.end_node     (end_node)
	);

endmodule
`default_nettype wire

/* hdl/tws_checker.sv */
// Port-level checks of the trie word store and their bind.
`default_nettype none
module tws_checker
	import tws_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic [1:0] kind,
	input wire logic [4:0] letter,
	input wire logic       has_letter,
	input wire logic       last,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [1:0] status,
	input wire logic [9:0] end_node
);

	// a stalled item holds its payload
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(kind) && $stable(letter)
			&& $stable(has_letter) && $stable(last))
		else $error("item changed while stalled");

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) && $stable(end_node))
		else $error("result changed while stalled");

	// only a hit names an end node
	a_node_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> (end_node == 10'd0))
		else $error("end_node set on a miss");

	// a new result follows a cycle in which no item was taken
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result rose right after an item transfer");

endmodule

bind trie_word_store tws_checker u_tws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.kind         (kind),
	.letter       (letter),
	.has_letter   (has_letter),
	.last         (last),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.end_node     (end_node)
);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench of the trie word store: random and directed words against a trie predictor.
module testbench;
	import tws_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One item on the input channel: one letter of a word, or a word end without a letter.
	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] letter;
		logic       has_letter;
		logic       last;
	} word_item_t;

	// The result of one finished word.
	typedef struct packed {
		logic [1:0] status;
		logic [9:0] end_node;
	} word_verdict_t;

	// A word of up to eight letters, kept so that later searches and deletes can hit it.
	typedef struct packed {
		logic [3:0]      len;
		logic [7:0][4:0] ch;
	} trie_word_t;

	localparam int LINK_DEPTH = NODE_COUNT_DEF * ALPHABET_DEF;

	// the kind code with no operation of its own; it acts as search
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [1:0] kind = KIND_INSERT;
	logic [4:0] letter = 5'd0;
	logic       has_letter = 1'b0;
	logic       last = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] status;
	logic [9:0] end_node;

	trie_word_store i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.letter      (letter),
		.has_letter  (has_letter),
		.last        (last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status      (status),
		.end_node    (end_node)
	);

	// Predictor state: our own copy of the trie and of the walk through it.
	bit [9:0] link_mem [0:LINK_DEPTH-1];
	bit       word_mark [0:NODE_COUNT_DEF-1];
	int       free_node = 1;
	int       walk_at = 0;
	bit       walk_stop = 1'b0;
	bit       pool_dry = 1'b0;

	word_item_t    pending_items [$];
	word_verdict_t word_verdicts [$];
	trie_word_t    inserted_words [$];

	word_item_t cur_item;
	logic       item_taken = 1'b0;
	int         item_gap = 0;
	int         send_calm = 0;
	int         stall_left = 0;
	int         recv_calm = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	int         results_seen = 0;
	int         fail_count = 0;
	int         item_count = 0;

	// Clock: 10 ns period.
	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the predicted trie by one transferred item; on a word end, queue its verdict.
	task automatic trie_take_item(input word_item_t it);
		int            slot;
		int            child;
		bit            empty;
		word_verdict_t v;
		if (it.has_letter && !walk_stop && !pool_dry) begin
			if (it.letter >= ALPHABET_DEF) begin
				walk_stop = 1'b1;
			end else begin
				slot = walk_at * ALPHABET_DEF + it.letter;
				child = int'(link_mem[slot]);
				if (child == 0) begin
					// Only insert letters may grow the trie; the others fail the walk.
					if (it.kind != KIND_INSERT) begin
						walk_stop = 1'b1;
					end else if (free_node >= NODE_COUNT_DEF) begin
						pool_dry = 1'b1;
					end else begin
						child = free_node;
						free_node++;
						word_mark[child] = 1'b0;
						link_mem[slot] = 10'(child);
					end
				end
				if (!walk_stop && !pool_dry)
					walk_at = child;
			end
		end
		if (!it.last)
			return;
		empty = (walk_at == 0) && !walk_stop && !pool_dry;
		v.status = ST_OK;
		v.end_node = 10'd0;
		if (it.kind == KIND_INSERT) begin
			if (pool_dry) begin
				v.status = ST_POOL_FULL;
			end else if (walk_stop) begin
				v.status = ST_NOT_FOUND;
			end else begin
				word_mark[walk_at] = 1'b1;
				v.end_node = 10'(walk_at);
			end
		end else if (it.kind == KIND_DELETE && empty) begin
			v.status = ST_EMPTY_DELETE;
		end else if (walk_stop || pool_dry || !word_mark[walk_at]) begin
			v.status = ST_NOT_FOUND;
		end else begin
			// Search and the unused kind only look; delete drops the mark.
			if (it.kind == KIND_DELETE)
				word_mark[walk_at] = 1'b0;
			v.end_node = 10'(walk_at);
		end
		word_verdicts.push_back(v);
		walk_at = 0;
		walk_stop = 1'b0;
		pool_dry = 1'b0;
	endtask

	// Sample both channels at the rising edge: predict on an item transfer, check on a result transfer.
	always @(posedge clk) begin
		word_verdict_t want;
		item_taken <= (item_valid === 1'b1) && (item_stall === 1'b0);
		if (arst_n) begin
			if (item_valid === 1'b1 && item_stall === 1'b0)
				trie_take_item('{kind, letter, has_letter, last});
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				results_seen++;
				if (word_verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d end_node %0d",
						$time, status, end_node);
					fail_count++;
				end else begin
					want = word_verdicts.pop_front();
					if (status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, status);
						fail_count++;
					end
					if (end_node !== want.end_node) begin
						$display("%0t: end_node mismatch, expected %0d, actual %0d",
							$time, want.end_node, end_node);
						fail_count++;
					end
				end
			end
		end
	end

	// Item driver: hold a stalled item, otherwise idle out the gap, then offer the next one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_taken) begin
				// hold the payload until the transfer
			end else if (item_gap > 0) begin
				item_gap--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				kind <= cur_item.kind;
				letter <= cur_item.letter;
				has_letter <= cur_item.has_letter;
				last <= cur_item.last;
				item_valid <= 1'b1;
				// Draw the gap after this item; now and then run a stretch with none.
				if (send_calm > 0) begin
					send_calm--;
					item_gap = 0;
				end else begin
					item_gap = pick_gap();
					if ($urandom_range(0, 49) == 0)
						send_calm = $urandom_range(20, 60);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, one long hold-off early on so the block backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 30) begin
				hold_done = 1'b1;
				hold_left = 400;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					stall_left = pick_gap();
					if ($urandom_range(0, 49) == 0)
						recv_calm = $urandom_range(20, 60);
				end
			end
		end
	end

	task automatic add_item(input logic [1:0] k, input logic [4:0] ch, input logic has,
			input logic fin);
		pending_items.push_back('{k, ch, has, fin});
		if (has || fin)
			item_count++;
	endtask

	// Queue one word; with scramble set, every letter but the last takes a random kind.
	task automatic add_word(input logic [1:0] op, input trie_word_t w, input bit scramble);
		logic [1:0] k;
		if (w.len == 0) begin
			add_item(op, 5'($urandom_range(0, 31)), 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < w.len; i++) begin
			k = (scramble && i < w.len - 1) ? 2'($urandom_range(0, 3)) : op;
			add_item(k, w.ch[i], 1'b1, i == w.len - 1);
		end
	endtask

	// Random traffic: mostly well-formed words over a few letters, some noise and broken words.
	task automatic add_random_traffic(input int n_items);
		int         start;
		int         r;
		int         pick;
		logic [1:0] op;
		trie_word_t w;
		start = item_count;
		while (item_count - start < n_items) begin
			r = $urandom_range(0, 99);
			w = '0;
			if (r < 8) begin
				// stray item without letter that does not end a word
				add_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0, 1'b0);
			end else if (r < 18) begin
				// broken word: mixed kinds, maybe an out-of-range letter
				w.len = 4'($urandom_range(1, 5));
				for (int i = 0; i < 8; i++)
					w.ch[i] = 5'($urandom_range(0, 3));
				if ($urandom_range(0, 1))
					w.ch[$urandom_range(0, w.len - 1)] = 5'($urandom_range(26, 31));
				add_word(2'($urandom_range(0, 3)), w, 1'b1);
			end else begin
				pick = $urandom_range(0, 99);
				op = (pick < 40) ? KIND_INSERT : (pick < 75) ? KIND_SEARCH :
					(pick < 95) ? KIND_DELETE : KIND_UNUSED;
				w.len = 4'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4));
				for (int i = 0; i < 8; i++)
					w.ch[i] = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 25) :
						$urandom_range(0, 3));
				// Aim most lookups at words already stored, sometimes at a prefix.
				if (op != KIND_INSERT && inserted_words.size() != 0 && $urandom_range(0, 2) != 0) begin
					w = inserted_words[$urandom_range(0, inserted_words.size() - 1)];
					if (w.len > 1 && $urandom_range(0, 3) == 0)
						w.len = w.len - 4'd1;
				end
				add_word(op, w, 1'b0);
				if (op == KIND_INSERT) begin
					inserted_words.push_back(w);
					if (inserted_words.size() > 64)
						void'(inserted_words.pop_front());
				end
			end
		end
	endtask

	// Pause the sender until every queued item went through and every result came back.
	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || word_verdicts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty words: search of an unmarked root, rejected delete, root insert and lookup, rejected delete again.
		add_item(KIND_SEARCH, 5'd0, 1'b0, 1'b1);
		add_item(KIND_DELETE, 5'd31, 1'b0, 1'b1);
		add_item(KIND_INSERT, 5'd0, 1'b0, 1'b1);
		add_item(KIND_SEARCH, 5'd0, 1'b0, 1'b1);
		add_item(KIND_DELETE, 5'd0, 1'b0, 1'b1);
		// "az": insert, find it with the unused kind, miss its prefix, delete it twice.
		add_item(KIND_INSERT, 5'd0, 1'b1, 1'b0);
		add_item(KIND_INSERT, 5'd25, 1'b1, 1'b1);
		add_item(KIND_UNUSED, 5'd0, 1'b1, 1'b0);
		add_item(KIND_UNUSED, 5'd25, 1'b1, 1'b1);
		add_item(KIND_SEARCH, 5'd0, 1'b1, 1'b1);
		add_item(KIND_DELETE, 5'd0, 1'b1, 1'b0);
		add_item(KIND_DELETE, 5'd25, 1'b1, 1'b1);
		add_item(KIND_DELETE, 5'd0, 1'b1, 1'b0);
		add_item(KIND_DELETE, 5'd25, 1'b1, 1'b1);
		// Letters past the alphabet fail the walk; later letters are ignored.
		add_item(KIND_INSERT, 5'd26, 1'b1, 1'b0);
		add_item(KIND_INSERT, 5'd1, 1'b1, 1'b1);
		add_item(KIND_SEARCH, 5'd31, 1'b1, 1'b1);
		// Letterless item inside a word, then a word closed by a letterless item.
		add_item(KIND_INSERT, 5'd1, 1'b1, 1'b0);
		add_item(KIND_INSERT, 5'd7, 1'b0, 1'b0);
		add_item(KIND_INSERT, 5'd2, 1'b1, 1'b1);
		add_item(KIND_INSERT, 5'd1, 1'b1, 1'b0);
		add_item(KIND_INSERT, 5'd0, 1'b0, 1'b1);
		// Mixed kinds: an insert letter grows, a search letter misses, insert after a miss.
		add_item(KIND_INSERT, 5'd3, 1'b1, 1'b0);
		add_item(KIND_SEARCH, 5'd4, 1'b1, 1'b1);
		add_item(KIND_SEARCH, 5'd5, 1'b1, 1'b0);
		add_item(KIND_INSERT, 5'd6, 1'b1, 1'b1);
		wait_drained();

		add_random_traffic(420);
		wait_drained();

		// Let any stray result surface before the verdict.
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("trie_word_store test passed");
		else
			$display("trie_word_store test failed");
		$finish;
	end

	// Watchdog: the clearing pass plus the slowest traffic fits well inside this.
	initial begin
		#5_000_000;
		$display("trie_word_store test failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/tws_pkg.sv
hdl/tws_ctrl.sv
hdl/tws_datapath.sv
hdl/trie_word_store.sv
hdl/tws_checker.sv
tb/testbench.sv
